/* src/assert_macros.svh */
// Assertion macros shared by the tension search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequence that must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* src/ctfts_pkg.sv */
// Types, codes and constants of the coarse-to-fine tension search.
`default_nettype none
package ctfts_pkg;

  // geometry of the beats
  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned FIELD_W           = 16;
  localparam int unsigned IN_TDATA_W        = 64;
  localparam int unsigned IN_TUSER_W        = 1;
  localparam int unsigned SCALE_W           = 15;
  localparam int unsigned PHASE_W           = 3;
  localparam int unsigned OUT_USED_W        = 2 * FIELD_W + 2 * SCALE_W + PHASE_W + 1;
  localparam int unsigned OUT_TDATA_W       = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W         = OUT_TDATA_W - OUT_USED_W;
  localparam int unsigned CFG_INDEX_W       = 3;
  localparam int unsigned CFG_DATA_W        = 16;

  // register widths
  localparam int unsigned THR_W  = 15;
  localparam int unsigned STEP_W = 14;
  localparam int unsigned DIV_W  = 16;

  // register reset values
  localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(50);
  localparam logic [STEP_W-1:0] COARSE_RST    = STEP_W'(600);
  localparam logic [STEP_W-1:0] MEDIUM_RST    = STEP_W'(300);
  localparam logic [STEP_W-1:0] FINE_RST      = STEP_W'(100);
  localparam logic [DIV_W-1:0]  DIVISOR_RST   = DIV_W'(570);

  localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_COARSE    = 3'd1,
    CFG_MEDIUM    = 3'd2,
    CFG_FINE      = 3'd3,
    CFG_DIVISOR   = 3'd4
  } cfg_reg_t;

  // input opcodes
  typedef enum logic [IN_TUSER_W-1:0] {
    OP_START  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  // search phase as reported
  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE   = 3'd0,
    PH_COARSE = 3'd1,
    PH_MEDIUM = 3'd2,
    PH_FINE   = 3'd3,
    PH_FINAL  = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP,
    S_DIFF_A,
    S_LOAD_A,
    S_DIV_A,
    S_DIFF_B,
    S_LOAD_B,
    S_DIV_B,
    S_SAVE_B,
    S_EMIT
  } ctl_state_t;

  // control of one serial position accumulator
  typedef struct packed {
    logic clear;
    logic load;
    logic shift;
    logic sub;
  } acc_ctl_t;

  // control of the serial divider
  typedef struct packed {
    logic load;
    logic shift;
  } div_ctl_t;

endpackage
`default_nettype wire

/* src/ctfts_serial_acc.sv */
// Bit-serial add/subtract accumulator holding one reference position.
`default_nettype none
module ctfts_serial_acc #(
  parameter int unsigned POSITION_BITS = ctfts_pkg::POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctfts_pkg::acc_ctl_t      ctl,
  input  logic [POSITION_BITS-1:0] operand,
  output logic [POSITION_BITS-1:0] ref_pos
);
  import ctfts_pkg::*;

  logic [POSITION_BITS-1:0] ref_r;
  logic [POSITION_BITS-1:0] opd_r;
  logic                     carry_r;
  logic                     sub_r;
  logic                     opd_bit;
  logic                     sum_bit;
  logic                     carry_out;

  // one full-adder slice, LSB first; subtract adds the inverted operand plus one
  assign opd_bit   = opd_r[0] ^ sub_r;
  assign sum_bit   = ref_r[0] ^ opd_bit ^ carry_r;
  assign carry_out = (ref_r[0] & opd_bit) | (ref_r[0] & carry_r) | (opd_bit & carry_r);

  // reference rotates through the slice, back in place after POSITION_BITS shifts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0;
    end else if (ctl.clear) begin
      ref_r <= '0;
    end else if (ctl.shift) begin
      ref_r <= {sum_bit, ref_r[POSITION_BITS-1:1]};
    end
  end

  // operand shift register and carry
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      opd_r   <= operand;
      carry_r <= ctl.sub;
      sub_r   <= ctl.sub;
    end else if (ctl.shift) begin
      opd_r   <= opd_r >> 1;
      carry_r <= carry_out;
    end
  end

  assign ref_pos = ref_r;

endmodule
`default_nettype wire

/* src/ctfts_serial_div.sv */
// Restoring divider producing one quotient bit per cycle while shift is asserted.
`default_nettype none
module ctfts_serial_div #(
  parameter int unsigned QW = 17
) (
  input  logic                        clk,
  input  ctfts_pkg::div_ctl_t         ctl,
  input  logic [QW-1:0]               dividend,
  input  logic [ctfts_pkg::DIV_W-1:0] divisor,
  output logic [QW-1:0]               quotient
);
  import ctfts_pkg::*;

  logic [DIV_W-1:0] rem_r;
  logic [QW-1:0]    dq_r;
  logic [DIV_W:0]   partial;
  logic [DIV_W+1:0] trial;
  logic             borrow;

  // bring down the next dividend bit and try the subtraction
  assign partial = {rem_r, dq_r[QW-1]};
  assign trial   = {1'b0, partial} - {2'b00, divisor};
  assign borrow  = trial[DIV_W+1];

  // dividend shifts out at the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem_r <= '0;
      dq_r  <= dividend;
    end else if (ctl.shift) begin
      rem_r <= borrow ? partial[DIV_W-1:0] : trial[DIV_W-1:0];
      dq_r  <= {dq_r[QW-2:0], ~borrow};
    end
  end

  assign quotient = dq_r;

endmodule
`default_nettype wire

/* src/coarse_to_fine_tension_search.sv */
// Top level of the two-motor coarse-to-fine cable tension search.
//
//  channel | direction | handshake            | content
//  --------+-----------+----------------------+-------------------------------------
//  in_     | slave     | in_tvalid/in_tready  | tuser opcode, tdata currents+positions
//  out_    | master    | out_tvalid/out_tready| tdata references, scales, phase, done
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data register write
//
// One beat is taken at a time. A start, an entry check or a phase end without
// back-off goes straight to the emit step; a reference step or back-off first
// runs the bit-serial accumulators. The final sample runs the shared serial
// divider once for each motor. A result waits in the output register while the
// next beat is taken; a stalled output only holds the sequencer at its emit step.
// rst_n is synchronous; configuration writes are taken every cycle.
`default_nettype none
`include "assert_macros.svh"
module coarse_to_fine_tension_search #(
  parameter int unsigned POSITION_BITS = ctfts_pkg::POSITION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] current_a, [31:16] current_b, [47:32] measured_pos_a, [63:48] measured_pos_b
  input  logic [ctfts_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] opcode
  input  logic [ctfts_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] reference_a, [31:16] reference_b, [46:32] scale_a, [61:47] scale_b,
  // [64:62] phase_now, [65] done_res, [71:66] zero
  output logic [ctfts_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ctfts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ctfts_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ctfts_pkg::*;

  localparam int unsigned QW    = ((POSITION_BITS > FIELD_W) ? POSITION_BITS : FIELD_W) + 1;
  localparam int unsigned CNT_W = $clog2(QW);

  ctl_state_t state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic       in_body_r, in_body_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [THR_W-1:0]  thr_r;
  logic [STEP_W-1:0] coarse_r;
  logic [STEP_W-1:0] medium_r;
  logic [STEP_W-1:0] fine_r;
  logic [DIV_W-1:0]  divisor_r;

  logic [FIELD_W-1:0] meas_a_r;
  logic [FIELD_W-1:0] meas_b_r;
  logic [QW-1:0]      diff_r;
  logic [SCALE_W-1:0] scale_a_r;
  logic [SCALE_W-1:0] scale_b_r;
  logic               out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  acc_ctl_t acc_ctl_a, acc_ctl_b;
  logic [POSITION_BITS-1:0] opd_a, opd_b;
  logic [POSITION_BITS-1:0] ref_a, ref_b;
  div_ctl_t div_ctl;
  logic [QW-1:0] dvd;
  logic [QW-1:0] quot;
  logic [SCALE_W-1:0] scale_q;

  logic [FIELD_W-1:0] cur_a, cur_b;
  logic               in_accept;
  logic               is_start;
  logic               searching;
  logic               need_a, need_b;
  logic signed [FIELD_W:0] neg_thr;
  logic [STEP_W-1:0]  step_sel;
  logic [STEP_W:0]    back_off;
  logic               out_free;
  logic               emit_load;
  logic               scales_zero;

  // beat decode
  assign cur_a     = in_tdata[FIELD_W-1:0];
  assign cur_b     = in_tdata[2*FIELD_W-1:FIELD_W];
  assign in_accept = in_tvalid && in_tready;
  assign is_start  = (in_tuser == OP_START);
  assign searching = (phase_r == PH_COARSE) || (phase_r == PH_MEDIUM) || (phase_r == PH_FINE);

  // tension tests: A below threshold, B above minus threshold
  assign neg_thr = -$signed({2'b00, thr_r});
  assign need_a  = $signed({cur_a[FIELD_W-1], cur_a}) < $signed({2'b00, thr_r});
  assign need_b  = $signed({cur_b[FIELD_W-1], cur_b}) > neg_thr;

  // step of the running phase
  always_comb begin
    case (phase_r)
      PH_COARSE: step_sel = coarse_r;
      PH_MEDIUM: step_sel = medium_r;
      default:   step_sel = fine_r;
    endcase
  end
  assign back_off = {step_sel, 1'b0};

  // position accumulators
  ctfts_serial_acc #(.POSITION_BITS(POSITION_BITS)) u_acc_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (acc_ctl_a),
    .operand (opd_a),
    .ref_pos (ref_a)
  );

  ctfts_serial_acc #(.POSITION_BITS(POSITION_BITS)) u_acc_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (acc_ctl_b),
    .operand (opd_b),
    .ref_pos (ref_b)
  );

  // shared divider, magnitude of the registered difference
  assign dvd = diff_r[QW-1] ? (~diff_r + QW'(1)) : diff_r;

  ctfts_serial_div #(.QW(QW)) u_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (dvd),
    .divisor  (divisor_r),
    .quotient (quot)
  );

  assign scale_q = (|quot[QW-1:SCALE_W]) ? SCALE_MAX : quot[SCALE_W-1:0];

  assign out_free  = !out_valid_r || out_tready;

  // sequencer: next state and control
  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    in_body_nxt = in_body_r;
    cnt_nxt     = cnt_r;
    acc_ctl_a   = '0;
    acc_ctl_b   = '0;
    opd_a       = '0;
    opd_b       = '0;
    div_ctl     = '0;
    in_tready   = 1'b0;
    emit_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = S_EMIT;
          if (is_start) begin
            acc_ctl_a.clear = 1'b1;
            acc_ctl_b.clear = 1'b1;
            phase_nxt       = PH_COARSE;
            in_body_nxt     = 1'b0;
          end else if (searching) begin
            if (!need_a && !need_b) begin
              // phase ends; back off after coarse and medium
              in_body_nxt = 1'b0;
              case (phase_r)
                PH_COARSE: phase_nxt = PH_MEDIUM;
                PH_MEDIUM: phase_nxt = PH_FINE;
                default:   phase_nxt = PH_FINAL;
              endcase
              if (phase_r != PH_FINE) begin
                acc_ctl_a.load = 1'b1;
                acc_ctl_a.sub  = 1'b0;
                acc_ctl_b.load = 1'b1;
                acc_ctl_b.sub  = 1'b1;
                opd_a          = POSITION_BITS'(back_off);
                opd_b          = POSITION_BITS'(back_off);
                cnt_nxt        = CNT_W'(POSITION_BITS - 1);
                state_nxt      = S_STEP;
              end
            end else if (!in_body_r) begin
              in_body_nxt = 1'b1;
            end else begin
              // step A down and B up where still slack
              acc_ctl_a.load = 1'b1;
              acc_ctl_a.sub  = 1'b1;
              acc_ctl_b.load = 1'b1;
              acc_ctl_b.sub  = 1'b0;
              opd_a          = POSITION_BITS'(need_a ? step_sel : '0);
              opd_b          = POSITION_BITS'(need_b ? step_sel : '0);
              cnt_nxt        = CNT_W'(POSITION_BITS - 1);
              state_nxt      = S_STEP;
            end
          end else if (phase_r == PH_FINAL) begin
            phase_nxt = PH_DONE;
            state_nxt = S_DIFF_A;
          end
        end
      end
      S_STEP: begin
        acc_ctl_a.shift = 1'b1;
        acc_ctl_b.shift = 1'b1;
        cnt_nxt         = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_EMIT;
        end
      end
      S_DIFF_A: begin
        state_nxt = S_LOAD_A;
      end
      S_LOAD_A: begin
        div_ctl.load = 1'b1;
        cnt_nxt      = CNT_W'(QW - 1);
        state_nxt    = S_DIV_A;
      end
      S_DIV_A: begin
        div_ctl.shift = 1'b1;
        cnt_nxt       = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_DIFF_B;
        end
      end
      S_DIFF_B: begin
        state_nxt = S_LOAD_B;
      end
      S_LOAD_B: begin
        div_ctl.load = 1'b1;
        cnt_nxt      = CNT_W'(QW - 1);
        state_nxt    = S_DIV_B;
      end
      S_DIV_B: begin
        div_ctl.shift = 1'b1;
        cnt_nxt       = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_SAVE_B;
        end
      end
      S_SAVE_B: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          emit_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // sequencer and search state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      phase_r   <= PH_IDLE;
      in_body_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      in_body_r <= in_body_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THRESHOLD_RST;
      coarse_r  <= COARSE_RST;
      medium_r  <= MEDIUM_RST;
      fine_r    <= FINE_RST;
      divisor_r <= DIVISOR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_r     <= cfg_data[THR_W-1:0];
        CFG_COARSE:    coarse_r  <= cfg_data[STEP_W-1:0];
        CFG_MEDIUM:    medium_r  <= cfg_data[STEP_W-1:0];
        CFG_FINE:      fine_r    <= cfg_data[STEP_W-1:0];
        CFG_DIVISOR:   divisor_r <= cfg_data[DIV_W-1:0];
        default:       ;
      endcase
    end
  end

  // positions and signed differences for the final sample
  always_ff @(posedge clk) begin
    if (in_accept) begin
      meas_a_r <= in_tdata[3*FIELD_W-1:2*FIELD_W];
      meas_b_r <= in_tdata[4*FIELD_W-1:3*FIELD_W];
    end
    if (state_r == S_DIFF_A) begin
      diff_r <= QW'($signed(meas_a_r)) - QW'($signed(ref_a));
    end else if (state_r == S_DIFF_B) begin
      diff_r <= QW'($signed(meas_b_r)) - QW'($signed(ref_b));
    end
  end

  // scale stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_a_r <= '0;
      scale_b_r <= '0;
    end else if (in_accept && is_start) begin
      scale_a_r <= '0;
      scale_b_r <= '0;
    end else if (state_r == S_DIFF_B) begin
      scale_a_r <= scale_q;
    end else if (state_r == S_SAVE_B) begin
      scale_b_r <= scale_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, (phase_r == PH_DONE), phase_r,
                     scale_b_r, scale_a_r, FIELD_W'(ref_b), FIELD_W'(ref_a)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  assign scales_zero = (scale_a_r == '0) && (scale_b_r == '0);

  `ASSERT_NEXT(a_accept_busy, in_accept, state_r != S_IDLE, "accepted beat left sequencer idle")
  `ASSERT_ALWAYS(a_body_phase, !in_body_r || searching, "in_body set outside a search phase")
  `ASSERT_ALWAYS(a_scale_clear, state_r != S_IDLE || phase_r == PH_DONE || scales_zero, "early scale")
  `ASSERT_NEXT(a_emit_valid, state_r == S_EMIT && out_free, out_tvalid, "emitted result not valid")

endmodule
`default_nettype wire

/* tb/sv/tension_search_checker.sv */
// Scoreboard for the tension search: tracks config, predicts each result beat and compares.
module tension_search_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [ctfts_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [ctfts_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [ctfts_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [ctfts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ctfts_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                mismatches,
  output int                                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ctfts_pkg::*;

  // input beat payload, highest field first
  typedef struct packed {
    logic signed [15:0] pos_b;
    logic signed [15:0] pos_a;
    logic signed [15:0] cur_b;
    logic signed [15:0] cur_a;
  } motor_sample_t;

  // result beat payload, highest field first
  typedef struct packed {
    logic               done;
    phase_t             phase;
    logic [SCALE_W-1:0] scale_b;
    logic [SCALE_W-1:0] scale_a;
    logic [15:0]        ref_b;
    logic [15:0]        ref_a;
  } search_status_t;

  // register copies
  logic [THR_W-1:0]  tension_thr;
  logic [STEP_W-1:0] coarse_step;
  logic [STEP_W-1:0] medium_step;
  logic [STEP_W-1:0] fine_step;
  logic [DIV_W-1:0]  scale_div;

  // search state
  phase_t             search_phase;
  logic               stepping;
  logic [15:0]        zero_a;
  logic [15:0]        zero_b;
  logic [SCALE_W-1:0] factor_a;
  logic [SCALE_W-1:0] factor_b;

  search_status_t expected_status[$];

  initial mismatches = 0;

  task automatic report(input string field, input int got_v, input int want_v);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got_v, want_v);
    mismatches++;
  endtask

  function automatic logic [STEP_W-1:0] step_of(input phase_t p);
    if (p == PH_COARSE) return coarse_step;
    if (p == PH_MEDIUM) return medium_step;
    return fine_step;
  endfunction

  // |measured - reference| / divisor, saturating at the scale width
  function automatic logic [SCALE_W-1:0] scale_from(input logic [15:0] meas,
                                                    input logic [15:0] zero);
    int          diff;
    int unsigned mag;
    int unsigned quo;
    diff = int'($signed(meas)) - int'($signed(zero));
    mag  = (diff < 0) ? -diff : diff;
    if (scale_div == '0) return SCALE_MAX;
    quo = mag / scale_div;
    return (quo > SCALE_MAX) ? SCALE_MAX : quo[SCALE_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    search_status_t got;
    search_status_t want;
    motor_sample_t  beat;
    logic           need_a;
    logic           need_b;
    logic [15:0]    backoff;
    if (!rst_n) begin
      tension_thr  = THRESHOLD_RST;
      coarse_step  = COARSE_RST;
      medium_step  = MEDIUM_RST;
      fine_step    = FINE_RST;
      scale_div    = DIVISOR_RST;
      search_phase = PH_IDLE;
      stepping     = 1'b0;
      zero_a       = '0;
      zero_b       = '0;
      factor_a     = '0;
      factor_b     = '0;
      expected_status.delete();
    end else begin
      // result beat against the oldest prediction
      if (out_tvalid && out_tready) begin
        got = search_status_t'(out_tdata[OUT_USED_W-1:0]);
        if (out_tdata[OUT_TDATA_W-1:OUT_USED_W] !== '0)
          report("padding", out_tdata[OUT_TDATA_W-1:OUT_USED_W], 0);
        if (expected_status.size() == 0) begin
          report("result beat with nothing pending", got.phase, 0);
        end else begin
          want = expected_status.pop_front();
          if (got.ref_a !== want.ref_a) report("reference_a", got.ref_a, want.ref_a);
          if (got.ref_b !== want.ref_b) report("reference_b", got.ref_b, want.ref_b);
          if (got.scale_a !== want.scale_a) report("scale_a", got.scale_a, want.scale_a);
          if (got.scale_b !== want.scale_b) report("scale_b", got.scale_b, want.scale_b);
          if (got.phase !== want.phase) report("phase_now", got.phase, want.phase);
          if (got.done !== want.done) report("done_res", got.done, want.done);
        end
      end

      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_THRESHOLD: tension_thr = cfg_data[THR_W-1:0];
          CFG_COARSE:    coarse_step = cfg_data[STEP_W-1:0];
          CFG_MEDIUM:    medium_step = cfg_data[STEP_W-1:0];
          CFG_FINE:      fine_step   = cfg_data[STEP_W-1:0];
          CFG_DIVISOR:   scale_div   = cfg_data[DIV_W-1:0];
          default: ;
        endcase
      end

      // accepted input beat advances the search
      if (in_tvalid && in_tready) begin
        beat = motor_sample_t'(in_tdata);
        if (opcode_t'(in_tuser) == OP_START) begin
          zero_a       = '0;
          zero_b       = '0;
          factor_a     = '0;
          factor_b     = '0;
          search_phase = PH_COARSE;
          stepping     = 1'b0;
        end else if (search_phase inside {PH_COARSE, PH_MEDIUM, PH_FINE}) begin
          need_a = int'(beat.cur_a) < int'(tension_thr);
          need_b = int'(beat.cur_b) > -int'(tension_thr);
          if (!need_a && !need_b) begin
            // phase over; back off after coarse and medium
            if (search_phase != PH_FINE) begin
              backoff = {1'b0, step_of(search_phase), 1'b0};
              zero_a  = zero_a + backoff;
              zero_b  = zero_b - backoff;
            end
            search_phase = phase_t'(search_phase + 1'b1);
            stepping     = 1'b0;
          end else if (!stepping) begin
            stepping = 1'b1;
          end else begin
            if (need_a) zero_a = zero_a - step_of(search_phase);
            if (need_b) zero_b = zero_b + step_of(search_phase);
          end
        end else if (search_phase == PH_FINAL) begin
          factor_a     = scale_from(beat.pos_a, zero_a);
          factor_b     = scale_from(beat.pos_b, zero_b);
          search_phase = PH_DONE;
        end
        want.ref_a   = zero_a;
        want.ref_b   = zero_b;
        want.scale_a = factor_a;
        want.scale_b = factor_b;
        want.phase   = search_phase;
        want.done    = (search_phase == PH_DONE);
        expected_status.push_back(want);
      end
    end
    pending = expected_status.size();
  end

endmodule

/* tb/sv/tb.sv */
// Testbench top: drives calibration runs and register settings into the tension search.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ctfts_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 40;
  localparam int SETTINGS_CNT = 9;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // [15:0] current_a, [31:16] current_b, [47:32] measured_pos_a, [63:48] measured_pos_b
  logic [IN_TDATA_W-1:0]  in_tdata;
  // [0] opcode
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  // [15:0] reference_a, [31:16] reference_b, [46:32] scale_a, [61:47] scale_b,
  // [64:62] phase_now, [65] done_res, [71:66] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     mismatches;
  int                     pending;

  int cycle_count = 0;
  int burst_left  = 0;
  int beats_sent  = 0;
  int stim_thr    = 50;
  int rx_mode     = 0;
  int rx_left     = 0;
  bit hold_req    = 1'b0;

  coarse_to_fine_tension_search DUT (.*);

  tension_search_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // result side: stall pattern in random stretches, plus one long hold on request
  initial begin : receiver
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(8, 80);
        end
        rx_left--;
        case (rx_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 1) == 1);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ((rx_left % 8) < 3);
        endcase
      end
    end
  end

  // one input beat; the sender runs in bursts separated by idle gaps
  task automatic send_beat(input opcode_t op, input logic [15:0] cur_a, input logic [15:0] cur_b,
                           input logic [15:0] pos_a, input logic [15:0] pos_b);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {pos_b, pos_a, cur_b, cur_a};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    beats_sent++;
  endtask

  // current on one side of the threshold, often right at the boundary
  function automatic logic [15:0] pick_current(input bit need, input bit is_b);
    int lo;
    int hi;
    if (!is_b) begin
      lo = need ? -32768 : stim_thr;
      hi = need ? stim_thr - 1 : 32767;
    end else begin
      lo = need ? 1 - stim_thr : -32768;
      hi = need ? 32767 : -stim_thr;
    end
    if ($urandom_range(0, 3) == 0) return 16'((need ^ is_b) ? hi : lo);
    return 16'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  // need[0]: motor A below threshold, need[1]: motor B above minus threshold
  task automatic send_sample(input logic [1:0] need);
    send_beat(OP_SAMPLE, pick_current(need[0], 1'b0), pick_current(need[1], 1'b1),
              16'($urandom), 16'($urandom));
  endtask

  // stop offering and wait for every pending result
  task automatic wait_drained();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input int thr, input int coarse, input int med, input int fin,
                            input int div);
    wait_drained();
    cfg_write(CFG_THRESHOLD, 16'(thr));
    cfg_write(CFG_COARSE, 16'(coarse));
    cfg_write(CFG_MEDIUM, 16'(med));
    cfg_write(CFG_FINE, 16'(fin));
    cfg_write(CFG_DIVISOR, 16'(div));
    cfg_valid <= 1'b0;
    stim_thr  = thr;
  endtask

  // one calibration: start, three phases, final sample; some get restarted midway
  task automatic run_search();
    int restart_at;
    restart_at = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 3) : 0;
    send_beat(OP_START, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    for (int p = 1; p <= 3; p++) begin
      if (p == restart_at)
        send_beat(OP_START, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      if ($urandom_range(0, 5) != 0) begin
        send_sample(2'($urandom_range(1, 3)));
        repeat ($urandom_range(0, 5)) send_sample(2'($urandom_range(1, 3)));
      end
      send_sample(2'b00);
    end
    send_beat(OP_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    if ($urandom_range(0, 3) == 0) send_sample(2'($urandom_range(0, 3)));
  endtask

  initial begin : stimulus
    int  start_cnt;
    bit  paused;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= OP_START;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_THRESHOLD;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed run on reset settings
    send_beat(OP_SAMPLE, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);  // ignored while idle
    send_beat(OP_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(OP_SAMPLE, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000);  // entry check
    send_beat(OP_SAMPLE, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000);  // both step
    send_beat(OP_SAMPLE, 16'd49, 16'h8000, 16'h1234, 16'h5678);    // only A steps
    send_beat(OP_SAMPLE, 16'h7FFF, 16'(-49), 16'h0000, 16'h0000);  // only B steps
    send_beat(OP_SAMPLE, 16'd50, 16'(-50), 16'h0000, 16'h0000);    // coarse ends, back-off
    send_beat(OP_SAMPLE, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);  // medium ends at entry
    send_beat(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);  // fine entry
    send_beat(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);  // fine step
    send_beat(OP_SAMPLE, 16'd100, 16'(-100), 16'h0000, 16'h0000);  // fine ends
    send_beat(OP_SAMPLE, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000);  // final sample
    send_beat(OP_SAMPLE, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000);  // ignored while done
    send_beat(OP_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_beat(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_beat(OP_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000);   // restart mid-phase
    send_beat(OP_SAMPLE, 16'd50, 16'(-50), 16'h0000, 16'h0000);
    send_beat(OP_SAMPLE, 16'd50, 16'(-50), 16'h0000, 16'h0000);
    send_beat(OP_SAMPLE, 16'd50, 16'(-50), 16'h0000, 16'h0000);
    send_beat(OP_SAMPLE, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF);

    // random runs over a range of settings, extremes first
    for (int k = 0; k < SETTINGS_CNT; k++) begin
      case (k)
        0: set_config(0, 16383, 16383, 16383, 2);
        1: set_config(32767, 0, 0, 0, 65535);
        2: set_config($urandom_range(0, 300), 600, 300, 100, 0);
        3: set_config($urandom_range(0, 300), $urandom_range(0, 16383),
                      $urandom_range(0, 16383), $urandom_range(0, 16383), 1);
        default: set_config(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                         : $urandom_range(0, 300),
                            $urandom_range(0, 16383), $urandom_range(0, 16383),
                            $urandom_range(0, 16383),
                            ($urandom_range(0, 1) == 1) ? $urandom_range(2, 1000)
                                                        : $urandom_range(2, 65535));
      endcase
      // long receiver hold while the sender keeps going
      if (k == 4) hold_req = 1'b1;
      start_cnt = beats_sent;
      paused    = 1'b0;
      while (beats_sent - start_cnt < PHASE_ITEMS) begin
        if (k == 6 && !paused && beats_sent - start_cnt > PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(0, 4) != 0) begin
          run_search();
        end else begin
          repeat ($urandom_range(1, 3))
            send_beat(($urandom_range(0, 4) == 0) ? OP_START : OP_SAMPLE, 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom));
        end
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
